// ===== rtl/core/pts_pkg.sv =====
`timescale 1ns / 1ps
package pts_pkg;

  localparam int TASKS_DEF = 16;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_SUSPEND = 3'd1,
    OP_RESUME  = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_YIELD   = 3'd4,
    OP_JOIN    = 3'd5,
    OP_STOP    = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    TS_UNUSED    = 3'd0,
    TS_CURRENT   = 3'd1,
    TS_READY     = 3'd2,
    TS_SUSPENDED = 3'd3,
    TS_STOPPED   = 3'd4
  } tstate_e;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_IGNORED  = 2'd1,
    RS_BAD_RES  = 2'd2,
    RS_NO_READY = 2'd3
  } rstat_e;

  // datapath action per cycle
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_LATCH = 3'd1,
    ACT_CHECK = 3'd2,
    ACT_SCAN  = 3'd3,
    ACT_WALK  = 3'd4,
    ACT_POP   = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    NX_OUT  = 2'd0,
    NX_SCAN = 2'd1,
    NX_POP  = 2'd2,
    NX_WALK = 2'd3
  } nxt_e;

  typedef struct packed {
    act_e act;
  } cmd_t;

  typedef struct packed {
    nxt_e check_next;
    nxt_e after_scan;
    logic scan_done;
    logic walk_end;
    logic walk_fail;
    logic walk_push;
  } sts_t;

endpackage

// ===== rtl/core/pts_ctrl.sv =====
`timescale 1ns / 1ps
module pts_ctrl
  import pts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WALK  = 6'b001000,
    S_POP   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  function automatic state_e go(nxt_e n);
    state_e r;
    case (n)
      NX_SCAN: r = S_SCAN;
      NX_POP:  r = S_POP;
      NX_WALK: r = S_WALK;
      default: r = S_OUT;
    endcase
    return r;
  endfunction

  always_comb begin
    state_d   = state_q;
    cmd_o.act = ACT_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_LATCH;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.act = ACT_CHECK;
        state_d   = go(sts_i.check_next);
      end
      S_SCAN: begin
        cmd_o.act = ACT_SCAN;
        if (sts_i.scan_done) state_d = go(sts_i.after_scan);
      end
      S_WALK: begin
        cmd_o.act = ACT_WALK;
        if (sts_i.walk_end) state_d = sts_i.walk_fail ? S_OUT : S_POP;
        else if (sts_i.walk_push) state_d = S_SCAN;
      end
      S_POP: begin
        cmd_o.act = ACT_POP;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// ===== rtl/core/pts_dp.sv =====
`timescale 1ns / 1ps
module pts_dp
  import pts_pkg::*;
#(
  parameter int TASKS = TASKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [2:0] op_i,
  input  logic [3:0] task_req_i,
  input  logic [6:0] priority_req_i,
  output sts_t       sts_o,
  output logic [1:0] status_o,
  output logic [3:0] current_task_o,
  output logic       switched_o,
  output logic       was_cancelled_o
);

  localparam int TW = $clog2(TASKS);
  localparam int CW = $clog2(TASKS + 1);
  localparam logic [CW-1:0] NONE = CW'(TASKS);

  tstate_e         tstate_q [TASKS];
  logic [6:0]      prio_q   [TASKS];
  logic            flag_q   [TASKS];
  logic [CW-1:0]   link_q   [TASKS];
  // ready list with a copy of each entry's priority
  logic [TW-1:0]   list_q   [TASKS];
  logic [6:0]      lprio_q  [TASKS];
  // membership of the ready list, a push of a listed task is dropped
  logic            inl_q    [TASKS];
  logic [CW-1:0]   count_q;
  logic [TW-1:0]   run_q;

  op_e             op_q;
  logic [3:0]      t_q;
  logic [6:0]      p_q;
  logic [TW-1:0]   ins_task_q;
  logic [6:0]      ins_prio_q;
  logic [CW-1:0]   i_q, n_q, w_q;
  logic [1:0]      res_status_q;
  logic            res_sw_q, res_canc_q;

  logic [TW-1:0]   t_idx, rd_addr, w_idx, head;
  logic            t_valid, found, dup;
  tstate_e         st_rd;
  logic [6:0]      prio_rd;
  logic [CW-1:0]   link_rd;
  logic            flag_rd;

  assign t_idx   = TW'(t_q);
  assign t_valid = 32'(t_q) < TASKS;
  assign w_idx   = w_q[TW-1:0];
  assign head    = list_q[0];

  always_comb begin
    case (cmd_i.act)
      ACT_CHECK: rd_addr = (op_q == OP_YIELD || op_q == OP_STOP) ? run_q : t_idx;
      ACT_WALK:  rd_addr = w_idx;
      ACT_POP:   rd_addr = head;
      default:   rd_addr = run_q;
    endcase
  end

  assign st_rd   = tstate_q[rd_addr];
  assign prio_rd = prio_q[rd_addr];
  assign link_rd = link_q[rd_addr];
  assign flag_rd = flag_q[rd_addr];

  assign found = (i_q == count_q) || (ins_prio_q < lprio_q[i_q[TW-1:0]]);
  assign dup   = inl_q[ins_task_q];

  always_comb begin
    sts_o.scan_done  = found || dup;
    sts_o.walk_end   = (n_q == CW'(TASKS)) || (w_q >= CW'(TASKS));
    sts_o.walk_fail  = (count_q == '0);
    sts_o.walk_push  = (st_rd == TS_SUSPENDED);
    case (op_q)
      OP_STOP:  sts_o.after_scan = NX_WALK;
      OP_YIELD: sts_o.after_scan = NX_POP;
      default:  sts_o.after_scan = NX_OUT;
    endcase
    case (op_q)
      OP_START:   sts_o.check_next = (!t_valid || st_rd != TS_UNUSED) ? NX_OUT : NX_SCAN;
      OP_SUSPEND: sts_o.check_next = (count_q == '0) ? NX_OUT : NX_POP;
      OP_RESUME:  sts_o.check_next = (!t_valid || st_rd != TS_SUSPENDED) ? NX_OUT : NX_SCAN;
      OP_CANCEL:  sts_o.check_next = (!t_valid || st_rd == TS_UNUSED || st_rd == TS_STOPPED
                                      || st_rd == TS_READY) ? NX_OUT : NX_SCAN;
      OP_YIELD:   sts_o.check_next = NX_SCAN;
      OP_JOIN:    sts_o.check_next = (!t_valid || st_rd == TS_UNUSED || t_idx == run_q
                                      || st_rd == TS_STOPPED || count_q == '0)
                                     ? NX_OUT : NX_POP;
      OP_STOP:    sts_o.check_next = NX_WALK;
      default:    sts_o.check_next = NX_OUT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TASKS; j++) begin
        tstate_q[j] <= (j == 0) ? TS_CURRENT : TS_UNUSED;
        prio_q[j]   <= '0;
        flag_q[j]   <= 1'b0;
        link_q[j]   <= NONE;
        inl_q[j]    <= 1'b0;
      end
      count_q <= '0;
      run_q   <= '0;
    end else begin
      case (cmd_i.act)
        ACT_CHECK: begin
          case (op_q)
            OP_START: begin
              if (t_valid && st_rd == TS_UNUSED) begin
                tstate_q[t_idx] <= TS_READY;
                prio_q[t_idx]   <= p_q;
                flag_q[t_idx]   <= 1'b0;
                link_q[t_idx]   <= NONE;
              end
            end
            OP_SUSPEND: if (count_q != '0) tstate_q[run_q] <= TS_SUSPENDED;
            OP_RESUME: begin
              if (t_valid && st_rd == TS_SUSPENDED) tstate_q[t_idx] <= TS_READY;
            end
            OP_CANCEL: begin
              if (t_valid && st_rd != TS_UNUSED && st_rd != TS_STOPPED) begin
                flag_q[t_idx]   <= 1'b1;
                tstate_q[t_idx] <= TS_READY;
              end
            end
            OP_YIELD: tstate_q[run_q] <= TS_READY;
            OP_JOIN: begin
              if (sts_o.check_next == NX_POP) begin
                link_q[run_q]   <= link_rd;
                link_q[t_idx]   <= CW'(run_q);
                tstate_q[run_q] <= TS_SUSPENDED;
              end
            end
            OP_STOP: tstate_q[run_q] <= TS_STOPPED;
            default: ;
          endcase
        end
        ACT_SCAN: begin
          if (found && !dup) begin
            for (int j = 1; j < TASKS; j++) begin
              if (CW'(j) > i_q && CW'(j) <= count_q) begin
                list_q[j]  <= list_q[j-1];
                lprio_q[j] <= lprio_q[j-1];
              end
            end
            list_q[i_q[TW-1:0]]  <= ins_task_q;
            lprio_q[i_q[TW-1:0]] <= ins_prio_q;
            inl_q[ins_task_q]    <= 1'b1;
            count_q <= count_q + 1'b1;
          end
        end
        ACT_WALK: begin
          if (sts_o.walk_end) begin
            // nothing became ready: undo the stop
            if (count_q == '0) tstate_q[run_q] <= TS_CURRENT;
            else link_q[run_q] <= NONE;
          end else if (st_rd == TS_SUSPENDED) begin
            tstate_q[w_idx] <= TS_READY;
          end
        end
        ACT_POP: begin
          tstate_q[head] <= TS_CURRENT;
          flag_q[head]   <= 1'b0;
          inl_q[head]    <= 1'b0;
          run_q          <= head;
          for (int j = 0; j < TASKS - 1; j++) begin
            list_q[j]  <= list_q[j+1];
            lprio_q[j] <= lprio_q[j+1];
          end
          count_q <= count_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ACT_LATCH: begin
        op_q <= op_e'(op_i);
        t_q  <= task_req_i;
        p_q  <= priority_req_i;
      end
      ACT_CHECK: begin
        res_sw_q   <= 1'b0;
        res_canc_q <= 1'b0;
        i_q        <= '0;
        n_q        <= '0;
        w_q        <= link_rd;
        ins_task_q <= (op_q == OP_YIELD) ? run_q : t_idx;
        ins_prio_q <= (op_q == OP_START) ? p_q : prio_rd;
        case (op_q)
          OP_START:   res_status_q <= (!t_valid || st_rd != TS_UNUSED) ? RS_IGNORED : RS_OK;
          OP_SUSPEND: res_status_q <= (count_q == '0) ? RS_NO_READY : RS_OK;
          OP_RESUME:  res_status_q <= !t_valid ? RS_IGNORED
                                    : (st_rd != TS_SUSPENDED) ? RS_BAD_RES : RS_OK;
          OP_CANCEL:  res_status_q <= (!t_valid || st_rd == TS_UNUSED || st_rd == TS_STOPPED)
                                      ? RS_IGNORED : RS_OK;
          OP_YIELD:   res_status_q <= RS_OK;
          OP_JOIN:    res_status_q <= (!t_valid || st_rd == TS_UNUSED || t_idx == run_q)
                                      ? RS_IGNORED
                                      : (st_rd != TS_STOPPED && count_q == '0)
                                      ? RS_NO_READY : RS_OK;
          OP_STOP:    res_status_q <= RS_OK;
          default:    res_status_q <= RS_IGNORED;
        endcase
      end
      ACT_SCAN: if (!found) i_q <= i_q + 1'b1;
      ACT_WALK: begin
        if (sts_o.walk_end) begin
          if (count_q == '0) res_status_q <= RS_NO_READY;
        end else begin
          if (st_rd == TS_SUSPENDED) begin
            ins_task_q <= w_idx;
            ins_prio_q <= prio_rd;
            i_q        <= '0;
          end
          w_q <= link_rd;
          n_q <= n_q + 1'b1;
        end
      end
      ACT_POP: begin
        res_sw_q     <= (head != run_q);
        res_canc_q   <= flag_rd;
        res_status_q <= RS_OK;
      end
      default: ;
    endcase
  end

  assign status_o        = res_status_q;
  assign current_task_o  = 4'(run_q);
  assign switched_o      = res_sw_q;
  assign was_cancelled_o = res_canc_q;

endmodule

// ===== rtl/core/priority_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// sequence: each op is latched and checked; an op that inserts then runs an ordered
//   insertion scan (skipped if the task is already listed), a stop walks its waiter
//   links, and an op that switches ends with a pop of the ready list head
// throughput: one word at a time, the insertion scan tests one entry a cycle
// reset: asynchronous active low, task 0 current, all others unused, ready list empty
module priority_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int TASKS = TASKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [3:0] task_req_i,
  input  logic [6:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] current_task_o,
  output logic       switched_o,
  output logic       was_cancelled_o
);

  // commands from the sequencer, status back from the task tables
  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // task tables, ready list and result word
  pts_dp #(.TASKS(TASKS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .task_req_i      (task_req_i),
    .priority_req_i  (priority_req_i),
    .sts_o           (sts),
    .status_o        (status_o),
    .current_task_o  (current_task_o),
    .switched_o      (switched_o),
    .was_cancelled_o (was_cancelled_o)
  );

  // one word in flight: never ready while a result waits
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // a result never shows in the cycle after an accept
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // failed or ignored ops report no switch
  a_err_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != RS_OK) |-> (!switched_o && !was_cancelled_o))
    else $error("switch flags on error status");

endmodule
